/* rtl/ghn_pkg.sv */
// Shared constants, types and helpers for the gray-level histogram normaliser.
package ghn_pkg;

   localparam int COUNT_BITS   = 24;
   localparam int NUM_BINS     = 256;
   localparam int INDEX_BITS   = 8;
   localparam int FIELD_BITS   = 24;
   localparam int HEIGHT_BITS  = 9;
   localparam int BAR_SHIFT    = 8;
   localparam int REM_BITS     = COUNT_BITS + BAR_SHIFT;
   localparam int STEP_BITS    = $clog2(HEIGHT_BITS);

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [FIELD_BITS-1:0]  FIELD_MAX = {FIELD_BITS{1'b1}};
   localparam logic [HEIGHT_BITS-1:0] BAR_FULL  = HEIGHT_BITS'(256);
   localparam logic [STEP_BITS-1:0]   LAST_STEP = STEP_BITS'(HEIGHT_BITS - 1);

   typedef enum logic [1:0] {
      CMD_ACCUMULATE = 2'd0,
      CMD_READ       = 2'd1,
      CMD_CLEAR      = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_READ,
      ST_DIV
   } state_type;

   // Clamps a bin count to the width of the result field.
   function automatic logic [FIELD_BITS-1:0] field_count(input logic [COUNT_BITS-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      if (w > 32'(FIELD_MAX)) begin
         return FIELD_MAX;
      end
      return w[FIELD_BITS-1:0];
   endfunction

endpackage

/* rtl/gray_histogram_normalizer.sv */
// Top level: 256-bin gray histogram with normalised bar heights.
//
// A request is taken when start is high and busy is low. req_cmd selects
// accumulate (count the pixel req_value), read (report bin req_value) or clear.
// Bin counts live in a single-port synchronous RAM with registered read
// data; a per-bin valid flag makes a bin that was never written since the
// last clear read as zero, so clear and reset need only drop the valid flags.
// Accumulate reads the bin, then writes back the saturated increment and
// updates the running peak. Clear drops the valid flags and zeroes the peak.
// When the peak is zero a read answers with a zero bar height; otherwise the
// bar height floor(count*256/peak) comes from a restoring divider that
// resolves one quotient bit per cycle, one for each of the nine height bits.
// A read answers with a one-cycle strobe on rsp_valid together with
// rsp_bin_index, rsp_bin_count and rsp_bar_height; the receiver must take it
// in that cycle, as it cannot stall the block. busy is high while a request
// is being worked on and drops in the same cycle as the response strobe starts.
// Synchronous reset empties every bin, zeroes the peak and idles the block.
module gray_histogram_normalizer
   import ghn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_cmd,
   input  logic [INDEX_BITS-1:0]  req_value,
   output logic                   rsp_valid,
   output logic [INDEX_BITS-1:0]  rsp_bin_index,
   output logic [FIELD_BITS-1:0]  rsp_bin_count,
   output logic [HEIGHT_BITS-1:0] rsp_bar_height
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]  mem [NUM_BINS];
   logic [COUNT_BITS-1:0]  rd_data_ff;
   logic                   rd_valid_ff;
   logic [NUM_BINS-1:0]    valid_ff, valid_in;
   logic                   mem_re;
   logic                   mem_we;
   logic [INDEX_BITS-1:0]  mem_addr;
   logic [COUNT_BITS-1:0]  mem_wdata;

   logic [INDEX_BITS-1:0]  index_ff, index_in;
   logic [COUNT_BITS-1:0]  peak_ff, peak_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [REM_BITS-1:0]    div_ff, div_in;
   logic [HEIGHT_BITS-1:0] quot_ff, quot_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [FIELD_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic [HEIGHT_BITS-1:0] rsp_height_ff, rsp_height_in;

   logic [COUNT_BITS-1:0]  cur_count;
   logic [COUNT_BITS-1:0]  inc_count;
   logic                   rem_ge;
   logic [HEIGHT_BITS-1:0] quot_next;

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_index  = rsp_index_ff;
   assign rsp_bin_count  = rsp_count_ff;
   assign rsp_bar_height = rsp_height_ff;

   assign cur_count = rd_valid_ff ? rd_data_ff : '0;
   assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
   assign rem_ge    = (rem_ff >= div_ff);
   assign quot_next = {quot_ff[HEIGHT_BITS-2:0], rem_ge};

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      index_in      = index_ff;
      peak_in       = peak_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_height_in = rsp_height_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = index_ff;
      mem_wdata     = inc_count;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mem_addr = req_value;
               index_in = req_value;
               case (cmd_type'(req_cmd))
                  CMD_ACCUMULATE: begin
                     mem_re   = 1'b1;
                     state_in = ST_ACC;
                  end
                  CMD_READ: begin
                     mem_re   = 1'b1;
                     state_in = ST_READ;
                  end
                  CMD_CLEAR: begin
                     valid_in = '0;
                     peak_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ACC: begin
            mem_we             = 1'b1;
            valid_in[index_ff] = 1'b1;
            if (inc_count > peak_ff) begin
               peak_in = inc_count;
            end
            state_in = ST_IDLE;
         end
         ST_READ: begin
            count_in = cur_count;
            if (peak_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = index_ff;
               rsp_count_in  = field_count(cur_count);
               rsp_height_in = '0;
               state_in      = ST_IDLE;
            end else begin
               rem_in   = {cur_count, {BAR_SHIFT{1'b0}}};
               div_in   = {peak_ff, {BAR_SHIFT{1'b0}}};
               quot_in  = '0;
               step_in  = LAST_STEP;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division: the divisor starts at peak*256 and halves each step.
            if (rem_ge) begin
               rem_in = rem_ff - div_ff;
            end
            div_in  = div_ff >> 1;
            quot_in = quot_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = index_ff;
               rsp_count_in  = field_count(count_ff);
               rsp_height_in = (quot_next > BAR_FULL) ? BAR_FULL : quot_next;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff      <= index_in;
      count_ff      <= count_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_height_ff <= rsp_height_in;
   end

   // Bin store: one port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff  <= mem[mem_addr];
         rd_valid_ff <= valid_ff[mem_addr];
      end
   end

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_height_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bar_height <= BAR_FULL))
      else $error("bar height above full scale");

   a_empty_height : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (peak_ff == '0)) |-> (rsp_bar_height == '0))
      else $error("non-zero bar height with an empty histogram");

   a_div_peak : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (peak_ff != '0))
      else $error("division started with a zero peak");

   a_count_le_peak : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (count_ff <= peak_ff))
      else $error("bin count above the running peak");

endmodule
